/* hdl/bec_pkg.sv */
// Shared types and constants for the byte entropy change monitor.
// Used by bec_ctrl, bec_dp and byte_entropy_change_monitor_top.
package bec_pkg;

  localparam logic [19:0] OUT_MAX       = 20'hFFFFF;
  localparam logic [6:0]  THR_RESET     = 7'd10;
  // ceil(2^32 / 100); exact floor(x/100) for x below 2^30
  localparam logic [25:0] RECIP100      = 26'd42949673;
  localparam int          RECIP_SHIFT   = 32;
  localparam logic        CMD_RECORD    = 1'b0;
  localparam logic        CMD_COMPARE   = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [3:0] region_index;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [19:0] entropy;
    logic [19:0] reference_entropy;
    logic        changed;
    logic        count_overflow;
  } out_word_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DRAIN,
    S_BIN_RD,
    S_BIN_CHK,
    S_LOG,
    S_MUL,
    S_ACC,
    S_DIV_INIT,
    S_DIV,
    S_NLOG,
    S_NSQ,
    S_FIN,
    S_REF,
    S_BAND,
    S_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic clr_we;
    logic bin_rd;
    logic bin_inc;
    logic log_load_bin;
    logic log_load_n;
    logic log_step;
    logic mul;
    logic acc_add;
    logic div_init;
    logic div_step;
    logic fin;
    logic ref_mul;
    logic band;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic bin_zero;
    logic bin_last;
    logic cnt_zero;
  } sts_t;

endpackage

/* hdl/bec_ctrl.sv */
// Sequencer for the monitor: histogram clear, byte intake, histogram sweep, log/divide steps and compare.
// Depends on bec_pkg; drives bec_dp through cmd_t and reads sts_t.
module bec_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          last,
  input  bec_pkg::sts_t sts,
  output bec_pkg::cmd_t cmd,
  output logic          busy
);
  import bec_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_we  = 1'b1;
        cmd.bin_inc = 1'b1;
        if (sts.bin_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.accept = 1'b1;
          if (last) state_next = S_DRAIN;
        end
      end
      // let the last byte's bin update land before the sweep
      S_DRAIN: state_next = S_BIN_RD;
      S_BIN_RD: begin
        cmd.bin_rd = 1'b1;
        state_next = S_BIN_CHK;
      end
      S_BIN_CHK: begin
        if (sts.bin_zero) begin
          cmd.bin_inc = 1'b1;
          state_next  = sts.bin_last ? S_DIV_INIT : S_BIN_RD;
        end else begin
          cmd.log_load_bin = 1'b1;
          state_next       = S_LOG;
        end
      end
      S_LOG: begin
        cmd.log_step = 1'b1;
        if (sts.cnt_zero) state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc_add = 1'b1;
        cmd.bin_inc = 1'b1;
        state_next  = sts.bin_last ? S_DIV_INIT : S_BIN_RD;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.cnt_zero) state_next = S_NLOG;
      end
      S_NLOG: begin
        cmd.log_load_n = 1'b1;
        state_next     = S_NSQ;
      end
      S_NSQ: begin
        cmd.log_step = 1'b1;
        if (sts.cnt_zero) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_REF;
      end
      S_REF: begin
        cmd.ref_mul = 1'b1;
        state_next  = S_BAND;
      end
      S_BAND: begin
        cmd.band   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.done   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* hdl/bec_dp.sv */
// Datapath: histogram memory, byte counter, log2 unit, accumulator,
// restoring divider, reference table and threshold compare. Uses bec_pkg.
module bec_dp #(
  parameter int MAX_REGIONS = 16,
  parameter int COUNT_BITS  = 24,
  parameter int FRAC_BITS   = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  bec_pkg::cmd_t     cmd,
  input  bec_pkg::in_word_t in_word,
  input  logic [6:0]        threshold,
  output bec_pkg::sts_t     sts,
  output logic              done,
  output bec_pkg::out_word_t result
);
  import bec_pkg::*;

  localparam int PW    = $clog2(COUNT_BITS);
  localparam int LOG_W = PW + FRAC_BITS;
  localparam int PRW   = COUNT_BITS + LOG_W;
  localparam int ACC_W = PRW + 8;
  localparam int CW    = $clog2(ACC_W);
  localparam int NW    = COUNT_BITS + 30;
  localparam int EW    = (LOG_W > 20) ? LOG_W : 20;
  localparam int TBL_DEPTH = (MAX_REGIONS < 16) ? MAX_REGIONS : 16;
  localparam int TAW   = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

  // histogram memory and byte intake pipeline
  logic [COUNT_BITS-1:0] hist [256];
  logic [COUNT_BITS-1:0] h_rdata, h_wdata, cur, inc;
  logic [7:0]            h_raddr, h_waddr, bin;
  logic                  h_we;
  logic                  p_valid, w_valid;
  logic [7:0]            p_addr, w_addr;
  logic [COUNT_BITS-1:0] w_data;
  logic [COUNT_BITS-1:0] byte_total;
  logic                  ovf;
  logic                  cmd_r;
  logic [3:0]            idx_r;

  assign h_raddr = cmd.accept ? in_word.data_byte : bin;
  assign h_we    = p_valid | cmd.clr_we | cmd.bin_rd;
  assign h_waddr = p_valid ? p_addr : bin;
  // previous word's write lands at the edge this read happened
  assign cur     = (w_valid && (w_addr == p_addr)) ? w_data : h_rdata;
  assign inc     = (&cur) ? cur : cur + 1'b1;
  assign h_wdata = p_valid ? inc : '0;

  always_ff @(posedge clk) begin
    h_rdata <= hist[h_raddr];
    if (h_we) hist[h_waddr] <= h_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      w_valid <= 1'b0;
      bin     <= '0;
    end else begin
      p_valid <= cmd.accept;
      w_valid <= p_valid;
      if (cmd.bin_inc) bin <= bin + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    p_addr <= in_word.data_byte;
    w_addr <= p_addr;
    w_data <= inc;
    if (cmd.accept) begin
      cmd_r <= in_word.cmd;
      idx_r <= in_word.region_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_total <= '0;
      ovf        <= 1'b0;
    end else if (cmd.done) begin
      byte_total <= '0;
      ovf        <= 1'b0;
    end else if (cmd.accept) begin
      if (&byte_total) ovf <= 1'b1;
      else byte_total <= byte_total + 1'b1;
    end
  end

  // log2 unit: leading one, then one squaring per fraction bit
  logic [COUNT_BITS-1:0] lx;
  logic [PW-1:0]         lz_p, lg_p;
  logic [NW-1:0]         norm;
  logic [30:0]           lg_m;
  logic [FRAC_BITS-1:0]  lg_f;
  logic [61:0]           sq;
  logic [31:0]           sq_t;
  logic [LOG_W-1:0]      lgv;
  logic [CW-1:0]         cnt;

  assign lx = cmd.log_load_n ? byte_total : h_rdata;

  always_comb begin
    lz_p = '0;
    for (int i = 0; i < COUNT_BITS; i++) begin
      if (lx[i]) lz_p = PW'(i);
    end
  end

  assign norm = {lx, 30'b0} >> lz_p;
  assign sq   = 62'(lg_m) * 62'(lg_m);
  assign sq_t = sq[61:30];
  assign lgv  = {lg_p, lg_f};

  always_ff @(posedge clk) begin
    if (cmd.log_load_bin || cmd.log_load_n) begin
      lg_p <= lz_p;
      lg_m <= norm[30:0];
      lg_f <= '0;
    end else if (cmd.log_step) begin
      lg_m <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
      lg_f <= {lg_f[FRAC_BITS-2:0], sq_t[31]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.log_load_bin || cmd.log_load_n) begin
      cnt <= CW'(FRAC_BITS - 1);
    end else if (cmd.div_init) begin
      cnt <= CW'(ACC_W - 1);
    end else if (cmd.log_step || cmd.div_step) begin
      cnt <= cnt - 1'b1;
    end
  end

  // sum of c*log2(c), then sum / n one quotient bit per cycle
  logic [COUNT_BITS-1:0] c_r, rem;
  logic [PRW-1:0]        prod;
  logic [ACC_W-1:0]      acc;
  logic [COUNT_BITS:0]   rem_w;
  logic                  ge;

  assign rem_w = {rem, acc[ACC_W-1]};
  assign ge    = rem_w >= {1'b0, byte_total};

  always_ff @(posedge clk) begin
    if (cmd.log_load_bin) c_r <= h_rdata;
    if (cmd.mul) prod <= PRW'(c_r) * PRW'(lgv);
    if (cmd.div_init) begin
      rem <= '0;
    end else if (cmd.div_step) begin
      rem <= ge ? COUNT_BITS'(rem_w - {1'b0, byte_total}) : rem_w[COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.done) begin
      acc <= '0;
    end else if (cmd.acc_add) begin
      acc <= acc + ACC_W'(prod);
    end else if (cmd.div_step) begin
      acc <= {acc[ACC_W-2:0], ge};
    end
  end

  // entropy = log2(n) - quotient, clamped at 0, saturated to 20 bits
  logic [LOG_W-1:0] diff;
  logic [19:0]      e_n, e_r;

  assign diff = lgv - acc[LOG_W-1:0];

  always_comb begin
    if (ACC_W'(lgv) <= acc) begin
      e_n = '0;
    end else if (EW'(diff) > EW'(OUT_MAX)) begin
      e_n = OUT_MAX;
    end else begin
      e_n = 20'(diff);
    end
  end

  // reference table with valid bits
  logic [19:0]          tbl [TBL_DEPTH];
  logic [TBL_DEPTH-1:0] tv;
  logic [TAW-1:0]       taddr;
  logic                 in_range, tbl_we;
  logic [19:0]          ref_rd, ref_r;
  logic                 ref_ok;
  logic [26:0]          pprod;
  logic [52:0]          bm;
  logic [20:0]          band_r;
  logic [21:0]          hi_b, lo_sum;
  logic                 outside;

  assign taddr    = TAW'(idx_r);
  assign in_range = 32'(idx_r) < MAX_REGIONS;
  assign tbl_we   = cmd.done && (cmd_r == CMD_RECORD) && in_range;
  assign bm       = pprod * RECIP100;
  assign hi_b     = {2'b0, ref_r} + {1'b0, band_r};
  assign lo_sum   = {2'b0, e_r} + {1'b0, band_r};
  assign outside  = ({2'b0, e_r} > hi_b) || (lo_sum < {2'b0, ref_r});

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      e_r    <= e_n;
      ref_rd <= tbl[taddr];
    end
    if (cmd.ref_mul) begin
      ref_r <= ref_ok ? ref_rd : '0;
      pprod <= 27'(ref_ok ? ref_rd : '0) * 27'(threshold);
    end
    if (cmd.band) band_r <= bm[RECIP_SHIFT+20:RECIP_SHIFT];
    if (tbl_we) tbl[taddr] <= e_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tv     <= '0;
      ref_ok <= 1'b0;
    end else begin
      if (cmd.fin) ref_ok <= in_range && tv[taddr];
      if (tbl_we) tv[taddr] <= 1'b1;
    end
  end

  // result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.done;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      result.entropy        <= e_r;
      result.count_overflow <= ovf;
      if (cmd_r == CMD_RECORD) begin
        result.reference_entropy <= in_range ? e_r : '0;
        result.changed           <= 1'b0;
      end else begin
        result.reference_entropy <= ref_r;
        result.changed           <= in_range ? outside : 1'b1;
      end
    end
  end

  assign sts.bin_zero = (h_rdata == '0);
  assign sts.bin_last = &bin;
  assign sts.cnt_zero = (cnt == '0);

endmodule

/* hdl/byte_entropy_change_monitor_top.sv */
// Top level of the byte entropy change monitor: threshold register,
// controller (bec_ctrl) and datapath (bec_dp). Uses bec_pkg.
//
// Bytes of a region are taken one per cycle while busy is low; a word is
// accepted when start is high and busy is low. After the word marked
// last_byte the block raises busy, waits in a drain state so the last bin
// update can land, then sweeps the 256 histogram bins, skipping empty bins
// and running the log2 squaring loop, multiply and accumulate on occupied
// ones, then a restoring divide with a setup step, a log2 of the byte
// count and the reference compare. The result shows on result with done
// high for a single cycle, the first cycle with busy low again; it cannot
// be held off. After reset the histogram is cleared with busy high.
module byte_entropy_change_monitor_top #(
  parameter int MAX_REGIONS = 16,
  parameter int COUNT_BITS  = 24,
  parameter int FRAC_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_data,
  input  logic               start,
  output logic               busy,
  input  bec_pkg::in_word_t  in_word,
  output logic               done,
  output bec_pkg::out_word_t result
);
  import bec_pkg::*;

  logic [6:0] threshold;
  cmd_t       cmd;
  sts_t       sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
    end else if (cfg_we) begin
      threshold <= cfg_data;
    end
  end

  bec_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .last  (in_word.last_byte),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  bec_dp #(
    .MAX_REGIONS (MAX_REGIONS),
    .COUNT_BITS  (COUNT_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_word   (in_word),
    .threshold (threshold),
    .sts       (sts),
    .done      (done),
    .result    (result)
  );

endmodule

/* tb/tb.sv */
// Self-checking testbench for byte_entropy_change_monitor_top.
// Streams byte regions, predicts entropy, reference, change flag and count
// overflow in a scoreboard class; depends only on bec_pkg and the RTL top.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bec_pkg::*;

  localparam longint unsigned COUNT_MAX = (64'd1 << 24) - 1;

  class entropy_tracker;
    int unsigned hist[256];
    int unsigned total;
    bit          ovf;
    logic [19:0] ref_tab[16];
    int unsigned thr;
    out_word_t   pending_results[$];
    int          errors;
    int          regions;
    int          changes;

    function void clear_all();
      foreach (hist[i]) hist[i] = 0;
      foreach (ref_tab[i]) ref_tab[i] = '0;
      total = 0;
      ovf = 0;
      thr = THR_RESET;
      errors = 0;
      regions = 0;
      changes = 0;
    endfunction

    // log2 with 16 truncated fraction bits, mantissa in Q1.30
    function longint unsigned fixed_log2(longint unsigned x);
      int unsigned p;
      longint unsigned m;
      longint unsigned frac;
      p = 0;
      frac = 0;
      if (x == 0) return 0;
      while (p < 63 && (x >> (p + 1)) != 0) p++;
      m = (p <= 30) ? (x << (30 - p)) : (x >> (p - 30));
      for (int k = 0; k < 16; k++) begin
        m = (m * m) >> 30;
        frac = frac << 1;
        if (m >= (64'd1 << 31)) begin
          frac = frac | 1;
          m = m >> 1;
        end
      end
      return (longint'(p) << 16) | frac;
    endfunction

    function logic [19:0] region_entropy();
      logic [127:0] sum;
      logic [127:0] q;
      logic [127:0] lg;
      sum = '0;
      for (int b = 0; b < 256; b++)
        if (hist[b] != 0) sum = sum + 128'(longint'(hist[b]) * fixed_log2(hist[b]));
      if (total == 0) return '0;
      q = sum / 128'(total);
      lg = 128'(fixed_log2(total));
      if (lg <= q) return '0;
      lg = lg - q;
      return (lg > 128'(OUT_MAX)) ? OUT_MAX : lg[19:0];
    endfunction

    function void note_word(in_word_t w);
      out_word_t r;
      longint band;
      if (total >= COUNT_MAX) ovf = 1;
      else total++;
      if (hist[w.data_byte] < COUNT_MAX) hist[w.data_byte]++;
      if (!w.last_byte) return;
      r.entropy = region_entropy();
      r.changed = 1'b0;
      if (w.cmd == CMD_RECORD) begin
        ref_tab[w.region_index] = r.entropy;
        r.reference_entropy = r.entropy;
      end else begin
        r.reference_entropy = ref_tab[w.region_index];
        band = (longint'(r.reference_entropy) * thr) / 100;
        r.changed = (longint'(r.entropy) > longint'(r.reference_entropy) + band) ||
                    (longint'(r.entropy) < longint'(r.reference_entropy) - band);
      end
      r.count_overflow = ovf;
      pending_results.push_back(r);
      foreach (hist[i]) hist[i] = 0;
      total = 0;
      ovf = 0;
    endfunction

    function void check_word(out_word_t r);
      out_word_t e;
      if (pending_results.size() == 0) begin
        $error("unexpected result word %h", r);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      regions++;
      if (r.changed) changes++;
      if (r.entropy !== e.entropy) begin
        $error("entropy: expected %h actual %h", e.entropy, r.entropy);
        errors++;
      end
      if (r.reference_entropy !== e.reference_entropy) begin
        $error("reference_entropy: expected %h actual %h",
               e.reference_entropy, r.reference_entropy);
        errors++;
      end
      if (r.changed !== e.changed) begin
        $error("changed: expected %b actual %b", e.changed, r.changed);
        errors++;
      end
      if (r.count_overflow !== e.count_overflow) begin
        $error("count_overflow: expected %b actual %b", e.count_overflow, r.count_overflow);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [6:0] cfg_data = '0;
  logic       start = 1'b0;
  logic       busy;
  in_word_t   in_word = '0;
  logic       done;
  out_word_t  result;

  entropy_tracker tracker = new();
  int  words_sent = 0;
  bit  gaps_on = 1'b1;
  logic [7:0] region_bytes[$];

  always #1 clk = ~clk;

  byte_entropy_change_monitor_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .start(start), .busy(busy), .in_word(in_word), .done(done), .result(result)
  );

  always @(posedge clk)
    if (!rst && done) tracker.check_word(result);

  // start stays high across back-to-back words; send_word lowers it only for a gap
  task automatic send_word(in_word_t w);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    tracker.note_word(w);
    words_sent++;
  endtask

  task automatic go_idle();
    start <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(logic [6:0] v);
    go_idle();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.thr = v;
  endtask

  task automatic send_region(logic cmd, logic [3:0] idx);
    in_word_t w;
    foreach (region_bytes[i]) begin
      w.cmd = cmd;
      w.region_index = idx;
      w.data_byte = region_bytes[i];
      w.last_byte = (i == region_bytes.size() - 1);
      send_word(w);
    end
  endtask

  // random bytes, usually short, from a narrow or full alphabet
  task automatic fill_region();
    int len;
    int span;
    logic [7:0] base;
    region_bytes.delete();
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    span = $urandom_range(0, 2) == 0 ? 255 : $urandom_range(0, 4);
    base = 8'($urandom);
    for (int i = 0; i < len; i++)
      region_bytes.push_back(8'(base + $urandom_range(0, span)));
  endtask

  task automatic random_phase(int n_words);
    logic [3:0] idx;
    int target;
    target = words_sent + n_words;
    while (words_sent < target) begin
      idx = 4'($urandom);
      fill_region();
      case ($urandom_range(0, 3))
        0: send_region(1'($urandom), idx);
        default: begin
          send_region(CMD_RECORD, idx);
          // replay, perhaps perturbed, to land near the band edge
          if ($urandom_range(0, 1))
            region_bytes[$urandom_range(0, region_bytes.size() - 1)] = 8'($urandom);
          if ($urandom_range(0, 2) == 0) region_bytes.push_back(8'($urandom));
          send_region(CMD_COMPARE, idx);
        end
      endcase
    end
  endtask

  initial begin
    tracker.clear_all();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    // directed: single-byte and short regions, extreme bytes and indexes, reset, zero and maximum thresholds
    region_bytes = '{8'h00};
    send_region(CMD_RECORD, 4'd0);
    region_bytes = '{8'hFF};
    send_region(CMD_COMPARE, 4'd15);
    region_bytes = '{8'h00, 8'hFF, 8'h55, 8'hAA};
    send_region(CMD_RECORD, 4'd15);
    send_region(CMD_COMPARE, 4'd15);
    region_bytes = '{8'h00, 8'hFF, 8'h55, 8'h55};
    send_region(CMD_COMPARE, 4'd15);
    region_bytes = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80};
    send_region(CMD_RECORD, 4'd5);
    send_region(CMD_COMPARE, 4'd10);
    write_threshold(7'd0);
    send_region(CMD_COMPARE, 4'd5);
    write_threshold(7'd127);
    region_bytes = '{8'h01, 8'h01};
    send_region(CMD_COMPARE, 4'd5);

    write_threshold(7'd100);
    random_phase(200);
    write_threshold(7'd0);
    random_phase(200);
    write_threshold(7'($urandom_range(1, 99)));
    random_phase(200);
    write_threshold(7'd127);
    random_phase(200);
    write_threshold(7'($urandom));
    gaps_on = 1'b0;
    random_phase(250);

    go_idle();
    repeat (20) @(posedge clk);
    $display("%0d words in %0d regions checked, %0d flagged changed, thresholds 0..127",
             words_sent, tracker.regions, tracker.changes);
    if (tracker.errors == 0 && tracker.pending_results.size() == 0)
      $display("byte_entropy_change_monitor_top verification clean");
    else
      $display("byte_entropy_change_monitor_top verification failed");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("byte_entropy_change_monitor_top verification failed");
    $finish;
  end
endmodule

/* filelist.f */
hdl/bec_pkg.sv
hdl/bec_ctrl.sv
hdl/bec_dp.sv
hdl/byte_entropy_change_monitor_top.sv
tb/tb.sv
